/* sv/fems_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and register indexes for the element match search.
// Used by every module of the block; depends on nothing.
package fems_pkg;

    // element and item geometry
    localparam int MAX_ELEMENT_BYTES = 16;
    localparam int BYTES_PER_ITEM    = 8;
    localparam int WORD_BYTES        = 8;
    localparam int SCAN_LANES        =
        (BYTES_PER_ITEM < WORD_BYTES) ? BYTES_PER_ITEM : WORD_BYTES;
    localparam int INDEX_BITS_DEF    = 32;

    // field widths
    localparam int DATA_W   = 64;
    localparam int COUNT_W  = 4;
    localparam int ESIZE_W  = 5;
    localparam int PHASE_W  = 4;
    localparam int RESIDX_W = 32;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_HIGH  = 2'd2;

    // configuration values seen by the scan logic
    typedef struct packed {
        logic [ESIZE_W-1:0] element_size;
        logic [DATA_W-1:0]  needle_low;
        logic [DATA_W-1:0]  needle_high;
    } t_cfg;

    // result of scanning one item
    typedef struct packed {
        logic                has_result;
        logic                found;
        logic [RESIDX_W-1:0] match_index;
    } t_scan_result;

endpackage

/* sv/fems_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file: element size and the two needle words.
// Depends on fems_pkg.
module fems_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [fems_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [fems_pkg::DATA_W-1:0]    i_cfg_data,
    output logic                           o_cfg_ready,
    output fems_pkg::t_cfg                 o_cfg
);
    import fems_pkg::*;

    logic [ESIZE_W-1:0] r_element_size;
    logic [DATA_W-1:0]  r_needle_low;
    logic [DATA_W-1:0]  r_needle_high;

    // writes are taken at any time
    assign o_cfg_ready = 1'b1;

    // register writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_size <= ESIZE_W'(1);
            r_needle_low   <= '0;
            r_needle_high  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ELEMENT_SIZE: r_element_size <= i_cfg_data[ESIZE_W-1:0];
                REG_NEEDLE_LOW:   r_needle_low   <= i_cfg_data;
                REG_NEEDLE_HIGH:  r_needle_high  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg.element_size = r_element_size;
    assign o_cfg.needle_low   = r_needle_low;
    assign o_cfg.needle_high  = r_needle_high;

endmodule

/* sv/fems_scan_core.sv */
`timescale 1ns / 1ps
// Search state and the byte lane scan of one item against the needle.
// Depends on fems_pkg.
module fems_scan_core #(
    parameter int INDEX_BITS = fems_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [fems_pkg::DATA_W-1:0]  i_data_word,
    input  logic [fems_pkg::COUNT_W-1:0] i_byte_count,
    input  logic                         i_last_item,
    input  fems_pkg::t_cfg               i_cfg,
    output fems_pkg::t_scan_result       o_result
);
    import fems_pkg::*;

    logic [PHASE_W-1:0]    r_byte_phase;
    logic                  r_element_matching;
    logic [INDEX_BITS-1:0] r_element_index;
    logic                  r_search_done;

    logic [PHASE_W-1:0]    n_byte_phase;
    logic                  n_element_matching;
    logic [INDEX_BITS-1:0] n_element_index;
    logic                  n_search_done;

    logic [ESIZE_W-1:0]    esize;
    logic [COUNT_W-1:0]    count_eff;
    logic [2*DATA_W-1:0]   needle;
    logic [PHASE_W-1:0]    phase;
    logic                  matching;
    logic                  done;
    logic                  hit;
    logic [COUNT_W-1:0]    n_comp;
    logic [COUNT_W-1:0]    hit_comp;
    logic [7:0]            hay_byte;
    logic [INDEX_BITS:0]   idx_sum;
    logic [INDEX_BITS:0]   hit_sum;
    logic [INDEX_BITS-1:0] idx_adv;
    logic [INDEX_BITS-1:0] hit_idx;
    logic [INDEX_BITS+RESIDX_W-1:0] hit_idx_ext;

    // clamp element size and byte count
    always_comb begin
        if (i_cfg.element_size == '0) begin
            esize = ESIZE_W'(1);
        end else if (i_cfg.element_size > ESIZE_W'(MAX_ELEMENT_BYTES)) begin
            esize = ESIZE_W'(MAX_ELEMENT_BYTES);
        end else begin
            esize = i_cfg.element_size;
        end
        if (i_byte_count > COUNT_W'(SCAN_LANES)) begin
            count_eff = COUNT_W'(SCAN_LANES);
        end else begin
            count_eff = i_byte_count;
        end
    end

    assign needle = {i_cfg.needle_high, i_cfg.needle_low};

    // byte lane chain: phase, match flag and element completions
    always_comb begin
        phase    = r_byte_phase;
        matching = r_element_matching;
        done     = r_search_done;
        hit      = 1'b0;
        n_comp   = '0;
        hit_comp = '0;
        hay_byte = '0;
        for (int i = 0; i < SCAN_LANES; i++) begin
            hay_byte = i_data_word[8*i +: 8];
            if ((COUNT_W'(i) < count_eff) && !done) begin
                if (hay_byte != needle[8*phase +: 8]) begin
                    matching = 1'b0;
                end
                if (({1'b0, phase} + ESIZE_W'(1)) >= esize) begin
                    if (matching) begin
                        hit      = 1'b1;
                        hit_comp = n_comp;
                        done     = 1'b1;
                    end
                    phase    = '0;
                    matching = 1'b1;
                    n_comp   = n_comp + COUNT_W'(1);
                end else begin
                    phase = phase + PHASE_W'(1);
                end
            end
        end
    end

    // saturating element index after the item and at the hit
    always_comb begin
        idx_sum = {1'b0, r_element_index} + (INDEX_BITS+1)'(n_comp);
        hit_sum = {1'b0, r_element_index} + (INDEX_BITS+1)'(hit_comp);
        idx_adv = idx_sum[INDEX_BITS] ? '1 : idx_sum[INDEX_BITS-1:0];
        hit_idx = hit_sum[INDEX_BITS] ? '1 : hit_sum[INDEX_BITS-1:0];
        hit_idx_ext = {{RESIDX_W{1'b0}}, hit_idx};
    end

    // result of this item
    always_comb begin
        o_result.has_result  = hit || (i_last_item && !done);
        o_result.found       = hit;
        o_result.match_index = hit ? hit_idx_ext[RESIDX_W-1:0] : '0;
    end

    // next search state, cleared at the end of a search
    always_comb begin
        if (i_last_item) begin
            n_byte_phase       = '0;
            n_element_matching = 1'b1;
            n_element_index    = '0;
            n_search_done      = 1'b0;
        end else begin
            n_byte_phase       = phase;
            n_element_matching = matching;
            n_element_index    = idx_adv;
            n_search_done      = done;
        end
    end

    // search state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_phase       <= '0;
            r_element_matching <= 1'b1;
            r_element_index    <= '0;
            r_search_done      <= 1'b0;
        end else if (i_fire) begin
            r_byte_phase       <= n_byte_phase;
            r_element_matching <= n_element_matching;
            r_element_index    <= n_element_index;
            r_search_done      <= n_search_done;
        end
    end

endmodule

/* sv/first_element_match_search.sv */
`timescale 1ns / 1ps
// Top level of the element match search: input register, scan core, result register.
// Depends on fems_pkg, fems_cfg_regs and fems_scan_core.

// The block takes one item of up to eight haystack bytes in every cycle that
// o_in_stall is low, and compares them, one lane per byte, against the
// configured needle in a single pass between the input register and the result
// register. A result (found with its element index, or not-found at the last
// item of a search) is registered as its item leaves the input register; most
// items give no result. A stalled result register holds the scan back, while
// one more item waits in the input register. Configuration writes are always
// ready and are meant for idle periods between searches; the search state
// returns to its start at every last item.
module first_element_match_search #(
    parameter int INDEX_BITS = fems_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [fems_pkg::DATA_W-1:0]     i_data_word,
    input  logic [fems_pkg::COUNT_W-1:0]    i_byte_count,
    input  logic                            i_last_item,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_found,
    output logic [fems_pkg::RESIDX_W-1:0]   o_match_index,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fems_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fems_pkg::DATA_W-1:0]     i_cfg_data
);
    import fems_pkg::*;

    logic                r_in_valid;
    logic [DATA_W-1:0]   r_data_word;
    logic [COUNT_W-1:0]  r_byte_count;
    logic                r_last_item;
    logic                r_out_valid;
    logic                r_found;
    logic [RESIDX_W-1:0] r_match_index;

    logic                fire;
    logic                load_in;
    t_cfg                cfg;
    t_scan_result        scan_res;

    // scan runs when an item waits and the result register can take a result
    assign fire    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign load_in = !r_in_valid || fire;
    assign o_in_stall = !load_in;

    fems_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    fems_scan_core #(
        .INDEX_BITS (INDEX_BITS)
    ) u_scan_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_data_word  (r_data_word),
        .i_byte_count (r_byte_count),
        .i_last_item  (r_last_item),
        .i_cfg        (cfg),
        .o_result     (scan_res)
    );

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (load_in && i_in_valid) begin
            r_data_word  <= i_data_word;
            r_byte_count <= i_byte_count;
            r_last_item  <= i_last_item;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && scan_res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (fire && scan_res.has_result) begin
            r_found       <= scan_res.found;
            r_match_index <= scan_res.match_index;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_match_index = r_match_index;

endmodule

/* bench/first_element_match_search_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for first_element_match_search: a directed table, then random searches
// checked against an in-bench search predictor. Depends on fems_pkg and the block's RTL.
module first_element_match_search_tb;
    import fems_pkg::*;

    localparam int IDX_BITS        = 32;
    localparam int RANDOM_ITEMS    = 600;
    localparam int MAX_IDLE        = 12;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int PRESSURE_ITEMS  = 24;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;
    typedef enum logic [1:0] { EXP_MODEL, EXP_NONE, EXP_MISS, EXP_HIT } t_row_expect;

    typedef struct packed {
        logic                found;
        logic [RESIDX_W-1:0] index;
    } t_search_result;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    value;
        logic [COUNT_W-1:0]   count;
        logic                 last;
        t_row_expect          how;
        logic [RESIDX_W-1:0]  hit_index;
    } t_stim_row;

    // block ports
    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [DATA_W-1:0]    i_data_word  = '0;
    logic [COUNT_W-1:0]   i_byte_count = '0;
    logic                 i_last_item  = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic                 o_found;
    logic [RESIDX_W-1:0]  o_match_index;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = REG_ELEMENT_SIZE;
    logic [DATA_W-1:0]    i_cfg_data   = '0;

    // predictor copy of registers and search state
    logic [ESIZE_W-1:0]   needle_size;
    logic [DATA_W-1:0]    needle_lo;
    logic [DATA_W-1:0]    needle_hi;
    logic [PHASE_W-1:0]   srch_phase;
    logic                 srch_matching;
    logic [IDX_BITS-1:0]  srch_index;
    logic                 srch_done;
    t_search_result       expected_results[$];

    // stimulus control
    logic [ESIZE_W-1:0]   plan_size;
    logic [127:0]         plan_needle;
    t_row_expect          item_expect    = EXP_MODEL;
    logic [RESIDX_W-1:0]  item_hit_index = '0;
    t_stim_row            directed_rows[$];
    int                   in_gap_max     = 0;
    int                   out_stall_max  = 0;
    bit                   hold_off_req   = 1'b0;
    int                   items_sent     = 0;
    int                   mismatch_count = 0;
    int                   quiet_cycles   = 0;

    always #5 i_clk = ~i_clk;

    first_element_match_search #(
        .INDEX_BITS(IDX_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_byte_count  (i_byte_count),
        .i_last_item   (i_last_item),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_match_index (o_match_index),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // element size as the block uses it: zero means one, large values clamp
    function automatic int elem_bytes(input logic [ESIZE_W-1:0] sz);
        if (sz == 0) return 1;
        if (sz > MAX_ELEMENT_BYTES) return MAX_ELEMENT_BYTES;
        return int'(sz);
    endfunction

    function automatic void clear_search();
        srch_phase    = '0;
        srch_matching = 1'b1;
        srch_index    = '0;
        srch_done     = 1'b0;
    endfunction

    // walk the valid bytes of one item through the element compare
    function automatic void scan_haystack_item(input logic [DATA_W-1:0] data,
                                               input logic [COUNT_W-1:0] count_in,
                                               input logic last,
                                               output logic has,
                                               output t_search_result res);
        int           esize;
        int           count;
        logic [127:0] needle;
        esize  = elem_bytes(needle_size);
        count  = (count_in > SCAN_LANES) ? SCAN_LANES : int'(count_in);
        needle = {needle_hi, needle_lo};
        has    = 1'b0;
        res    = '0;
        for (int i = 0; i < count && !srch_done; i++) begin
            if (data[8*i +: 8] != needle[8*srch_phase +: 8])
                srch_matching = 1'b0;
            if (srch_phase + 1 >= esize) begin
                if (srch_matching) begin
                    has       = 1'b1;
                    res.found = 1'b1;
                    res.index = srch_index;
                    srch_done = 1'b1;
                end
                srch_phase    = '0;
                srch_matching = 1'b1;
                if (srch_index != '1)
                    srch_index++;
            end else begin
                srch_phase++;
            end
        end
        if (last) begin
            if (!has && !srch_done) begin
                has = 1'b1;
                res = '0;
            end
            clear_search();
        end
    endfunction

    // check results, track register writes, predict each accepted item
    always @(posedge i_clk) begin : scoreboard
        t_search_result got;
        t_search_result want;
        t_search_result pred;
        logic           has;
        if (!i_rst_n) begin
            needle_size = 5'd1;
            needle_lo   = '0;
            needle_hi   = '0;
            clear_search();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got.found = o_found;
                got.index = o_match_index;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual found=%0b index=%0d",
                             $time, got.found, got.index);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, got.found);
                        mismatch_count++;
                    end
                    if (got.index !== want.index) begin
                        $display("%0t: match_index mismatch: expected %0d, actual %0d",
                                 $time, want.index, got.index);
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ELEMENT_SIZE: needle_size = i_cfg_data[ESIZE_W-1:0];
                    REG_NEEDLE_LOW:   needle_lo   = i_cfg_data;
                    REG_NEEDLE_HIGH:  needle_hi   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                scan_haystack_item(i_data_word, i_byte_count, i_last_item, has, pred);
                case (item_expect)
                    EXP_MODEL: if (has) expected_results.push_back(pred);
                    EXP_MISS:  expected_results.push_back('0);
                    EXP_HIT:   expected_results.push_back({1'b1, item_hit_index});
                    default: ;
                endcase
            end
        end
    end

    // no transaction on any channel for too long ends the run
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: random stall before each transaction, one long hold-off on request
    initial begin : result_sink
        int hold;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold         = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                hold = $urandom_range(0, out_stall_max);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input logic [DATA_W-1:0] data, input logic [COUNT_W-1:0] count,
                             input logic last, input t_row_expect how,
                             input logic [RESIDX_W-1:0] hit_idx);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_data_word    <= data;
        i_byte_count   <= count;
        i_last_item    <= last;
        item_expect    <= how;
        item_hit_index <= hit_idx;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // wait until every expected result is out and the pipeline has drained
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write; valid stays up so writes can go back to back
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic end_writes();
        i_cfg_valid <= 1'b0;
    endtask

    // build one haystack of whole elements (copies, near misses, random) and feed it in
    task automatic run_search(input int n_elems, input bit plant, input bit close);
        logic [7:0]        hay[$];
        logic [7:0]        flip;
        logic [DATA_W-1:0] w;
        int                e;
        int                pos;
        int                kind;
        int                flip_at;
        int                c;
        int                field;
        e   = elem_bytes(plan_size);
        pos = (plant && n_elems > 0) ? $urandom_range(0, n_elems - 1) : -1;
        for (int k = 0; k < n_elems; k++) begin
            kind    = (k == pos) ? 0 : $urandom_range(0, 15);
            flip_at = $urandom_range(0, e - 1);
            flip    = 8'($urandom_range(1, 255));
            for (int j = 0; j < e; j++) begin
                if (kind == 0)
                    hay.push_back(plan_needle[8*j +: 8]);
                else if (kind <= 4)
                    hay.push_back(plan_needle[8*j +: 8] ^ ((j == flip_at) ? flip : 8'h00));
                else
                    hay.push_back(8'($urandom));
            end
        end
        // needle prefix at the tail that never completes an element
        if (e > 1 && $urandom_range(0, 3) == 0) begin
            c = $urandom_range(1, e - 1);
            for (int j = 0; j < c; j++)
                hay.push_back(plan_needle[8*j +: 8]);
        end
        do begin
            c = $urandom_range(0, SCAN_LANES);
            if (c > hay.size())
                c = hay.size();
            field = (c == SCAN_LANES && $urandom_range(0, 3) == 0) ?
                    $urandom_range(9, 15) : c;
            w = {$urandom, $urandom};
            for (int j = 0; j < c; j++)
                w[8*j +: 8] = hay.pop_front();
            send_item(w, COUNT_W'(field), close && hay.size() == 0, EXP_MODEL, '0);
        end while (hay.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_needle();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void row_item(input logic [DATA_W-1:0] data,
                                     input logic [COUNT_W-1:0] count, input logic last,
                                     input t_row_expect how, input logic [RESIDX_W-1:0] hit_idx);
        t_stim_row row;
        row.kind      = ROW_ITEM;
        row.reg_idx   = REG_ELEMENT_SIZE;
        row.value     = data;
        row.count     = count;
        row.last      = last;
        row.how       = how;
        row.hit_index = hit_idx;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] value);
        t_stim_row row;
        row.kind      = ROW_CFG;
        row.reg_idx   = idx;
        row.value     = value;
        row.count     = '0;
        row.last      = 1'b0;
        row.how       = EXP_NONE;
        row.hit_index = '0;
        directed_rows.push_back(row);
    endfunction

    initial begin : stimulus
        bit                writing;
        int                random_start;
        int                phase_no;
        int                n_search;
        logic [DATA_W-1:0] size_word;

        // after reset: one-byte elements, zero needle
        row_item(64'h0, 4'd0, 1'b1, EXP_MISS, 32'd0);                   // empty search
        row_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, EXP_MISS, 32'd0);
        row_item(64'h0000_0000_0000_00FF, 4'd8, 1'b0, EXP_HIT, 32'd1);
        row_item(64'h0, 4'd8, 1'b0, EXP_NONE, 32'd0);                   // consumed after match
        row_item(64'h0, 4'd15, 1'b1, EXP_NONE, 32'd0);                  // silent end
        row_item(64'h00FF_FFFF_FFFF_FFFF, 4'd15, 1'b1, EXP_HIT, 32'd7); // count clamps to 8
        row_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, EXP_NONE, 32'd0);
        // sixteen-byte elements across both needle halves
        row_cfg(REG_ELEMENT_SIZE, 64'd16);
        row_cfg(REG_NEEDLE_LOW, 64'h0123_4567_89AB_CDEF);
        row_cfg(REG_NEEDLE_HIGH, 64'hFEDC_BA98_7654_3210);
        row_item(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, EXP_NONE, 32'd0);
        row_item(64'hFEDC_BA98_7654_3210, 4'd8, 1'b1, EXP_HIT, 32'd0);  // match on last item
        row_item(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, EXP_NONE, 32'd0);
        row_item(64'hFEDC_BA98_7654_3210, 4'd7, 1'b1, EXP_MISS, 32'd0); // partial element
        row_item(64'h0123_4567_89AB_CCEF, 4'd8, 1'b0, EXP_MODEL, 32'd0);
        row_item(64'hFEDC_BA98_7654_3210, 4'd8, 1'b0, EXP_MODEL, 32'd0);
        row_item(64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, EXP_MODEL, 32'd0);
        row_item(64'hFEDC_BA98_7654_3210, 4'd8, 1'b1, EXP_MODEL, 32'd0);
        // size zero acts as one
        row_cfg(REG_ELEMENT_SIZE, 64'd0);
        row_cfg(REG_NEEDLE_LOW, 64'h0000_0000_0000_00AA);
        row_item(64'hAA00_0000_0000_0000, 4'd8, 1'b0, EXP_HIT, 32'd7);
        row_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, EXP_NONE, 32'd0);
        // oversized element size clamps to sixteen, upper data bits ignored
        row_cfg(REG_ELEMENT_SIZE, 64'hFFFF_FFFF_FFFF_FFFF);
        row_cfg(REG_NEEDLE_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        row_cfg(REG_NEEDLE_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        row_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, EXP_NONE, 32'd0);
        row_item(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, EXP_HIT, 32'd0);
        row_item(64'h0, 4'd0, 1'b1, EXP_NONE, 32'd0);
        // element size shrinks while an element is half done
        row_cfg(REG_ELEMENT_SIZE, 64'd3);
        row_cfg(REG_NEEDLE_LOW, 64'h0000_0000_0055_AA11);
        row_item(64'hFFFF_FFFF_FFFF_AA11, 4'd2, 1'b0, EXP_NONE, 32'd0);
        row_cfg(REG_ELEMENT_SIZE, 64'd2);
        row_item(64'h1234_5678_9ABC_DE55, 4'd1, 1'b1, EXP_MODEL, 32'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        in_gap_max    = 3;
        out_stall_max = 3;
        writing       = 1'b0;
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                if (!writing)
                    settle_idle();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
                writing = 1'b1;
            end else begin
                if (writing)
                    end_writes();
                writing = 1'b0;
                send_item(directed_rows[r].value, directed_rows[r].count,
                          directed_rows[r].last, directed_rows[r].how,
                          directed_rows[r].hit_index);
            end
        end

        // random phases: new registers, idling mode and a batch of searches each
        random_start = items_sent;
        phase_no     = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            settle_idle();
            case ($urandom_range(0, 3))
                0: begin in_gap_max = 0;        out_stall_max = 0;        end
                1: begin in_gap_max = MAX_IDLE; out_stall_max = 0;        end
                2: begin in_gap_max = 0;        out_stall_max = MAX_IDLE; end
                default: begin in_gap_max = MAX_IDLE; out_stall_max = MAX_IDLE; end
            endcase
            case ($urandom_range(0, 9))
                0:       plan_size = 5'd1;
                1:       plan_size = 5'd16;
                2:       plan_size = 5'd0;
                3:       plan_size = ESIZE_W'($urandom_range(17, 31));
                default: plan_size = ESIZE_W'($urandom_range(1, 16));
            endcase
            plan_needle = {pick_needle(), pick_needle()};
            size_word   = {$urandom, $urandom};
            size_word[ESIZE_W-1:0] = plan_size;
            write_reg(REG_ELEMENT_SIZE, size_word);
            write_reg(REG_NEEDLE_LOW, plan_needle[63:0]);
            write_reg(REG_NEEDLE_HIGH, plan_needle[127:64]);
            end_writes();
            if (phase_no == 3) begin
                // one-item searches back to back while the result side holds off
                in_gap_max    = 0;
                out_stall_max = 0;
                hold_off_req  = 1'b1;
                repeat (PRESSURE_ITEMS)
                    send_item({$urandom, $urandom}, COUNT_W'($urandom_range(0, 8)), 1'b1,
                              EXP_MODEL, '0);
            end else begin
                n_search = $urandom_range(3, 8);
                for (int s = 0; s < n_search; s++) begin
                    if ($urandom_range(0, 5) == 0) begin
                        // raw noise items
                        repeat ($urandom_range(1, 4))
                            send_item({$urandom, $urandom}, COUNT_W'($urandom_range(0, 15)),
                                      $urandom_range(0, 3) == 0, EXP_MODEL, '0);
                    end else begin
                        run_search($urandom_range(0, 12), $urandom_range(0, 9) < 7,
                                   s < n_search - 1 || $urandom_range(0, 2) != 0);
                    end
                end
            end
            phase_no++;
        end

        // drain and report
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* files.f */
sv/fems_pkg.sv
sv/fems_cfg_regs.sv
sv/fems_scan_core.sv
sv/first_element_match_search.sv
bench/first_element_match_search_tb.sv
